[src/ordered_list_with_delete_macros.svh]
// Assertion macros used by the list back end.
`ifndef ORDERED_LIST_WITH_DELETE_MACROS_SVH
`define ORDERED_LIST_WITH_DELETE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define OLWD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define OLWD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OLWD_ASSERT_IMP(lbl, ante, cons, msg)
`define OLWD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[src/olwd_pkg.sv]
// Types, codes and defaults for the ordered list block.
package olwd_pkg;

	localparam int DEPTH_DEFAULT = 16;

	// command codes on the input word
	localparam logic [2:0] CMD_CLEAR     = 3'd0;
	localparam logic [2:0] CMD_APPEND    = 3'd1;
	localparam logic [2:0] CMD_REM_FIRST = 3'd2;
	localparam logic [2:0] CMD_REM_LAST  = 3'd3;
	localparam logic [2:0] CMD_REM_VALUE = 3'd4;

	// status codes on the result word
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] entry_count;
	} rsp_t;

	// decoded operation, as held in the queue
	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_REM_FIRST,
		OP_REM_LAST,
		OP_REM_VALUE,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} qent_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_SHIFT_RD,
		S_SHIFT_WR
	} state_t;

	function automatic op_t decode(input logic [2:0] command);
		op_t op;
		case (command)
			CMD_CLEAR:     op = OP_CLEAR;
			CMD_APPEND:    op = OP_APPEND;
			CMD_REM_FIRST: op = OP_REM_FIRST;
			CMD_REM_LAST:  op = OP_REM_LAST;
			CMD_REM_VALUE: op = OP_REM_VALUE;
			default:       op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

[src/olwd_front.sv]
// Front end: takes command words, decodes them and queues them for the back end.
module olwd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  olwd_pkg::cmd_t      cmd,
	output logic                q_valid,
	input  logic                q_pop,
	output olwd_pkg::qent_t     q_head
);

	// two-entry queue
	olwd_pkg::qent_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;
	logic            push;
	logic            pop;

	assign cmd_ready = (fill_q != 2'd2);
	assign push      = cmd_valid && cmd_ready;
	assign q_valid   = (fill_q != 2'd0);
	assign pop       = q_pop && q_valid;
	assign q_head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].op    <= olwd_pkg::decode(cmd.command);
			slot_q[wr_ptr_q].value <= cmd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[src/olwd_back.sv]
// Back end: list store, command sequencer and result register.
`include "ordered_list_with_delete_macros.svh"

module olwd_back #(
	parameter int DEPTH = olwd_pkg::DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  olwd_pkg::qent_t  q_head,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output olwd_pkg::rsp_t   rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]       mem [DEPTH];
	logic [31:0]       rdata_q;
	logic [31:0]       val_q;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              rsp_valid_q;
	olwd_pkg::rsp_t    rsp_q;
	olwd_pkg::state_t  state_q;
	olwd_pkg::state_t  state_d;

	// memory and control strobes
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [31:0]       mem_wd;
	logic [AW-1:0]     mem_ra;
	logic              fin;
	logic [1:0]        fin_status;
	logic              cnt_inc;
	logic              cnt_dec;
	logic              cnt_clr;
	logic              idx_inc;
	logic              idx_clr;
	logic              load_val;

	logic              empty;
	logic              full;
	logic              take;
	logic [CW-1:0]     cnt_m1;
	logic              scan_last;
	logic              shift_last;
	logic              hit;
	logic [CW-1:0]     cnt_next;
	logic [31:0]       cnt_wide;

	assign empty      = (count_q == '0);
	assign full       = (count_q == CW'(DEPTH));
	assign take       = q_valid && !rsp_valid_q;
	assign cnt_m1     = count_q - CW'(1);
	assign scan_last  = (CW'(idx_q) == cnt_m1);
	assign shift_last = ((CW'(idx_q) + CW'(1)) == cnt_m1);
	assign hit        = (rdata_q == val_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			olwd_pkg::S_IDLE: begin
				if (take && !empty) begin
					if (q_head.op == olwd_pkg::OP_REM_VALUE) begin
						state_d = olwd_pkg::S_SCAN_RD;
					end else if (q_head.op == olwd_pkg::OP_REM_FIRST &&
							count_q != CW'(1)) begin
						state_d = olwd_pkg::S_SHIFT_RD;
					end
				end
			end
			olwd_pkg::S_SCAN_RD: state_d = olwd_pkg::S_SCAN_EV;
			olwd_pkg::S_SCAN_EV: begin
				if (hit) begin
					state_d = scan_last ? olwd_pkg::S_IDLE : olwd_pkg::S_SHIFT_RD;
				end else begin
					state_d = scan_last ? olwd_pkg::S_IDLE : olwd_pkg::S_SCAN_RD;
				end
			end
			olwd_pkg::S_SHIFT_RD: state_d = olwd_pkg::S_SHIFT_WR;
			olwd_pkg::S_SHIFT_WR: begin
				state_d = shift_last ? olwd_pkg::S_IDLE : olwd_pkg::S_SHIFT_RD;
			end
			default: state_d = olwd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = idx_q;
		mem_wd     = rdata_q;
		mem_ra     = idx_q;
		fin        = 1'b0;
		fin_status = olwd_pkg::STAT_DONE;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		cnt_clr    = 1'b0;
		idx_inc    = 1'b0;
		idx_clr    = 1'b0;
		load_val   = 1'b0;
		case (state_q)
			olwd_pkg::S_IDLE: begin
				if (take) begin
					q_pop = 1'b1;
					case (q_head.op)
						olwd_pkg::OP_CLEAR: begin
							cnt_clr = 1'b1;
							fin     = 1'b1;
						end
						olwd_pkg::OP_APPEND: begin
							fin = 1'b1;
							if (full) begin
								fin_status = olwd_pkg::STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								mem_wa  = count_q[AW-1:0];
								mem_wd  = q_head.value;
								cnt_inc = 1'b1;
							end
						end
						olwd_pkg::OP_REM_LAST: begin
							fin = 1'b1;
							if (empty) fin_status = olwd_pkg::STAT_EMPTY;
							else       cnt_dec    = 1'b1;
						end
						olwd_pkg::OP_REM_FIRST: begin
							if (empty) begin
								fin        = 1'b1;
								fin_status = olwd_pkg::STAT_EMPTY;
							end else if (count_q == CW'(1)) begin
								fin     = 1'b1;
								cnt_dec = 1'b1;
							end else begin
								idx_clr = 1'b1;
							end
						end
						olwd_pkg::OP_REM_VALUE: begin
							if (empty) begin
								fin        = 1'b1;
								fin_status = olwd_pkg::STAT_EMPTY;
							end else begin
								idx_clr  = 1'b1;
								load_val = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			olwd_pkg::S_SCAN_RD: mem_ra = idx_q;
			olwd_pkg::S_SCAN_EV: begin
				if (hit) begin
					if (scan_last) begin
						fin     = 1'b1;
						cnt_dec = 1'b1;
					end
				end else if (scan_last) begin
					fin        = 1'b1;
					fin_status = olwd_pkg::STAT_NOT_FOUND;
				end else begin
					idx_inc = 1'b1;
				end
			end
			olwd_pkg::S_SHIFT_RD: mem_ra = idx_q + AW'(1);
			olwd_pkg::S_SHIFT_WR: begin
				mem_we = 1'b1;
				mem_wa = idx_q;
				mem_wd = rdata_q;
				if (shift_last) begin
					fin     = 1'b1;
					cnt_dec = 1'b1;
				end else begin
					idx_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cnt_next = count_q;
		if (cnt_clr)      cnt_next = '0;
		else if (cnt_inc) cnt_next = count_q + CW'(1);
		else if (cnt_dec) cnt_next = cnt_m1;
	end
	assign cnt_wide = 32'(cnt_next);

	// list store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (load_val) val_q <= q_head.value;
		if (fin) begin
			rsp_q.status      <= fin_status;
			rsp_q.entry_count <= cnt_wide[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olwd_pkg::S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cnt_next;
			if (idx_clr)      idx_q <= '0;
			else if (idx_inc) idx_q <= idx_q + AW'(1);
			if (fin)            rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`OLWD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`OLWD_ASSERT_IMP(a_pop_when_free, q_pop, state_q == olwd_pkg::S_IDLE && !rsp_valid_q, "command taken while busy")
	`OLWD_ASSERT_IMP(a_busy_no_result, state_q != olwd_pkg::S_IDLE, !rsp_valid_q, "result pending during a walk")
	`OLWD_ASSERT_NXT(a_count_only_on_fin, !fin, $stable(count_q), "count moved without a result")

endmodule

[src/ordered_list_with_delete.sv]
// Top level of the ordered list: front end, command queue and back end.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+---------------------------------
//  cmd     | in  | cmd_valid / cmd_ready | olwd_pkg::cmd_t (command, value)
//  rsp     | out | rsp_valid / rsp_ready | olwd_pkg::rsp_t (status, count)
//
// Clear, append, remove-last, unknown codes and commands on an empty list finish from
// the idle state; remove-first shifts later entries down in the list store, remove-value
// scans for the value and then shifts, each step a read followed by a compare or write.
// Reset empties the list at once; no sweep of the store is needed.
// The two-word front queue keeps taking commands, as long as a word is free, while
// the back end walks the store or a result waits in the output register for rsp_ready.
// The back end takes the next queued command only once the previous result has gone.
module ordered_list_with_delete #(
	parameter int DEPTH = olwd_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  olwd_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output olwd_pkg::rsp_t  rsp
);

	// queue head towards the back end
	logic            q_valid;
	logic            q_pop;
	olwd_pkg::qent_t q_head;

	// front: decode and buffer up to two command words
	olwd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head)
	);

	// back: list store, walk sequencer and result register
	olwd_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
